@@ design/dss_pkg.sv @@
// Shared types and codes for the DPLL SAT solver block.
package dss_pkg;

    localparam int LIT_W = 8;
    localparam int NV_W  = 7;

    typedef logic [LIT_W-1:0] lit_t;

    typedef enum logic [1:0] {
        RES_SAT   = 2'd0,
        RES_UNSAT = 2'd1,
        RES_OVF   = 2'd2
    } res_t;

    typedef enum logic [1:0] {
        LV_FALSE = 2'd0,
        LV_TRUE  = 2'd1,
        LV_UNDEF = 2'd2
    } lval_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_UNIT,
        ST_PROP_CHECK,
        ST_PROP_LIT,
        ST_PROP_SCAN,
        ST_BUMP_RD,
        ST_BUMP_WR,
        ST_BT_RD,
        ST_BT_EV,
        ST_BT_FIN,
        ST_DEC_SCAN,
        ST_DEC_DONE,
        ST_DEC_ASSIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic scan_prop;
        logic trail_rd_pp;
        logic set_lit;
        logic pp_inc;
        logic bump_rd;
        logic bump_wr;
        logic dec_start;
        logic dec_step;
        logic push_marker;
        logic push_dec;
        logic bt_init;
        logic bt_rd;
        logic bt_pop;
        logic bt_fin;
        logic emit;
        res_t emit_code;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic ovf;
        logic lp_zero;
        logic tail;
        logic unsat;
        logic conflict;
        logic pp_lt_len;
        logic trail_lit_zero;
        logic eff_zero;
        logic dec_last;
        logic dec_found;
        logic depth_zero;
        logic trail_empty;
        logic out_free;
    } sts_t;

endpackage

@@ design/dss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/dss_ctrl.sv @@
// Sequencer for load, unit scan, propagation, backtrack, decision and result.
module dss_ctrl
    import dss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic last,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    res_t   res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            res_reg   <= RES_SAT;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (sts.ovf)
                begin
                    res_next   = RES_OVF;
                    state_next = ST_EMIT;
                end
                else if (sts.lp_zero)
                begin
                    state_next = ST_PROP_CHECK;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_UNIT;
                end
            end
            ST_UNIT:
            begin
                cmd.scan_step = 1'b1;
                if (sts.unsat)
                begin
                    res_next   = RES_UNSAT;
                    state_next = ST_EMIT;
                end
                else if (sts.tail)
                begin
                    state_next = ST_PROP_CHECK;
                end
            end
            ST_PROP_CHECK:
            begin
                if (sts.pp_lt_len)
                begin
                    cmd.trail_rd_pp = 1'b1;
                    state_next      = ST_PROP_LIT;
                end
                else if (sts.eff_zero)
                begin
                    res_next   = RES_SAT;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.dec_start = 1'b1;
                    state_next    = ST_DEC_SCAN;
                end
            end
            ST_PROP_LIT:
            begin
                if (sts.trail_lit_zero || sts.lp_zero)
                begin
                    cmd.pp_inc = 1'b1;
                    state_next = ST_PROP_CHECK;
                end
                else
                begin
                    cmd.set_lit    = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_PROP_SCAN;
                end
            end
            ST_PROP_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.scan_prop = 1'b1;
                if (sts.conflict)
                begin
                    state_next = ST_BUMP_RD;
                end
                else if (sts.tail)
                begin
                    cmd.pp_inc = 1'b1;
                    state_next = ST_PROP_CHECK;
                end
            end
            ST_BUMP_RD:
            begin
                cmd.bump_rd = 1'b1;
                state_next  = ST_BUMP_WR;
            end
            ST_BUMP_WR:
            begin
                cmd.bump_wr = 1'b1;
                if (sts.depth_zero)
                begin
                    res_next   = RES_UNSAT;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.bt_init = 1'b1;
                    state_next  = ST_BT_RD;
                end
            end
            ST_BT_RD:
            begin
                if (sts.trail_empty)
                begin
                    state_next = ST_BT_FIN;
                end
                else
                begin
                    cmd.bt_rd  = 1'b1;
                    state_next = ST_BT_EV;
                end
            end
            ST_BT_EV:
            begin
                cmd.bt_pop = 1'b1;
                if (sts.trail_lit_zero)
                begin
                    state_next = ST_BT_FIN;
                end
                else
                begin
                    state_next = ST_BT_RD;
                end
            end
            ST_BT_FIN:
            begin
                cmd.bt_fin = 1'b1;
                state_next = ST_PROP_CHECK;
            end
            ST_DEC_SCAN:
            begin
                cmd.dec_step = 1'b1;
                if (sts.dec_last)
                begin
                    state_next = ST_DEC_DONE;
                end
            end
            ST_DEC_DONE:
            begin
                if (!sts.dec_found)
                begin
                    res_next   = RES_SAT;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.push_marker = 1'b1;
                    state_next      = ST_DEC_ASSIGN;
                end
            end
            ST_DEC_ASSIGN:
            begin
                cmd.push_dec = 1'b1;
                state_next   = ST_PROP_CHECK;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_code = res_reg;
                    cmd.clear     = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

@@ design/dss_datapath.sv @@
// Solver datapath: clause store, trail, activity counts, assignment and result.
module dss_datapath
    import dss_pkg::*;
#(
    parameter int MAX_VARS       = 64,
    parameter int MAX_LITS       = 1024,
    parameter int ACTIVITY_WIDTH = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [NV_W-1:0]     cfg_write_data,
    input  lit_t                literal,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [1:0]          status,
    output logic [MAX_VARS-1:0] assignment
);

    localparam int VIW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int TDEPTH = 2 * MAX_VARS;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int TLW    = $clog2(TDEPTH + 1);
    localparam int SAW    = $clog2(MAX_LITS);
    localparam int LPW    = $clog2(MAX_LITS + 1);
    localparam int DW     = $clog2(MAX_VARS + 1);
    localparam int AW     = ACTIVITY_WIDTH;
    localparam logic [NV_W-1:0] NV_MAX = NV_W'(MAX_VARS);

    function automatic lit_t lit_mag(lit_t l);
        return l[LIT_W-1] ? lit_t'(lit_t'(0) - l) : l;
    endfunction

    function automatic logic [VIW-1:0] vidx(lit_t l);
        return VIW'(lit_mag(l) - lit_t'(1));
    endfunction

    function automatic lval_t lv(lit_t l, logic [MAX_VARS-1:0] a, logic [MAX_VARS-1:0] v);
        logic [VIW-1:0] i;
        i = vidx(l);
        if (!a[i])
        begin
            return LV_UNDEF;
        end
        return (v[i] ^ l[LIT_W-1]) ? LV_TRUE : LV_FALSE;
    endfunction

    logic [NV_W-1:0]     nv_reg;
    logic [LPW-1:0]      lp_reg;
    logic                open_reg;
    logic                ovf_reg;
    logic [MAX_VARS-1:0] asg_reg;
    logic [MAX_VARS-1:0] val_reg;
    logic [MAX_VARS-1:0] act_vld_reg;
    logic [TLW-1:0]      tl_reg;
    logic [TLW-1:0]      pp_reg;
    logic [DW-1:0]       depth_reg;
    lit_t                cur_lit_reg;
    lit_t                bt_lit_reg;
    logic [SAW-1:0]      pos_reg;
    logic [1:0]          cnt_reg;
    lit_t                acc_reg;
    logic                has_reg;
    logic                st_reg;
    logic [VIW-1:0]      dcnt_reg;
    logic [AW-1:0]       best_reg;
    logic [NV_W-1:0]     bidx_reg;
    logic                ld_pend_reg;
    logic [VIW-1:0]      rd_addr_reg;
    logic                rd_vld_reg;
    logic                wr_done_reg;
    logic [VIW-1:0]      wr_addr_reg;
    logic [AW-1:0]       wr_data_reg;
    logic                out_valid_reg;
    res_t                status_reg;
    logic [MAX_VARS-1:0] assign_reg;

    logic [NV_W-1:0]     eff;
    logic [MAX_VARS-1:0] mask;
    lit_t                mag_in;
    logic                lit_nz;
    logic                lp_full;
    logic                in_range;
    logic                closes;
    logic                ld_store;
    logic                ld_ovf;
    logic                ld_bump;

    lit_t                store_rdata;
    logic [SAW-1:0]      store_raddr;
    lit_t                trail_rdata;
    logic [TAW-1:0]      trail_raddr;
    logic                trail_we;
    logic [AW-1:0]       act_rdata;
    logic [VIW-1:0]      act_raddr;
    logic [AW-1:0]       actv;
    logic [AW-1:0]       act_inc;
    logic                act_we;
    logic                cand;

    lit_t                opp;
    logic                nz;
    lval_t               dv;
    lval_t               uv;
    logic [1:0]          cnt_n;
    lit_t                acc_n;
    logic                has_n;
    logic                st_n;
    logic                counting;
    logic                close;
    logic                scan_assign;
    logic                unsat;
    logic                conflict;

    logic                push_en;
    lit_t                push_lit;

    assign eff = (nv_reg > NV_MAX) ? NV_MAX : nv_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_VARS; i++)
        begin
            mask[i] = NV_W'(i) < eff;
        end
    end

    // load path
    assign mag_in   = lit_mag(literal);
    assign lit_nz   = literal != '0;
    assign lp_full  = lp_reg >= LPW'(MAX_LITS);
    assign in_range = mag_in <= {1'b0, eff};
    assign closes   = !lit_nz && (lp_reg != '0) && open_reg;
    assign ld_store = cmd.load && !ovf_reg && !lp_full && ((lit_nz && in_range) || closes);
    assign ld_ovf   = cmd.load && !ovf_reg &&
                      ((lit_nz && (!in_range || lp_full)) || (closes && lp_full));
    assign ld_bump  = ld_store && lit_nz;

    // activity counts with one-deep write forwarding
    always_comb
    begin
        if (cmd.load)
        begin
            act_raddr = vidx(literal);
        end
        else if (cmd.bump_rd)
        begin
            act_raddr = vidx(cur_lit_reg);
        end
        else if (cmd.dec_step)
        begin
            act_raddr = dcnt_reg + VIW'(1);
        end
        else
        begin
            act_raddr = '0;
        end
    end

    assign actv    = (wr_done_reg && (wr_addr_reg == rd_addr_reg)) ? wr_data_reg :
                     (rd_vld_reg ? act_rdata : '0);
    assign act_inc = (&actv) ? actv : actv + AW'(1);
    assign act_we  = ld_pend_reg || cmd.bump_wr;
    assign cand    = !asg_reg[dcnt_reg] && (actv >= best_reg);

    // clause scan
    assign store_raddr = cmd.scan_step ? pos_reg + SAW'(1) : '0;
    assign nz          = store_rdata != '0;
    assign opp         = lit_t'(lit_t'(0) - cur_lit_reg);
    assign dv          = lv(store_rdata, asg_reg, val_reg);
    assign counting    = nz && !st_reg;
    assign sts.tail    = LPW'(pos_reg) == (lp_reg - LPW'(1));
    assign close       = !nz || sts.tail;

    always_comb
    begin
        cnt_n = cnt_reg;
        acc_n = acc_reg;
        has_n = has_reg;
        st_n  = st_reg;
        if (!cmd.scan_prop)
        begin
            if (nz)
            begin
                cnt_n = (cnt_reg == 2'd2) ? cnt_reg : cnt_reg + 2'd1;
                if (cnt_reg == 2'd0)
                begin
                    acc_n = store_rdata;
                end
            end
        end
        else
        begin
            has_n = has_reg || (nz && (store_rdata == opp));
            st_n  = st_reg || (counting && (dv == LV_TRUE));
            if (counting && (dv == LV_UNDEF))
            begin
                cnt_n = (cnt_reg == 2'd2) ? cnt_reg : cnt_reg + 2'd1;
                acc_n = store_rdata;
            end
        end
    end

    assign uv = lv(acc_n, asg_reg, val_reg);

    always_comb
    begin
        scan_assign = 1'b0;
        unsat       = 1'b0;
        conflict    = 1'b0;
        if (cmd.scan_step && close)
        begin
            if (!cmd.scan_prop)
            begin
                if (cnt_n == 2'd1)
                begin
                    unsat       = uv == LV_FALSE;
                    scan_assign = uv == LV_UNDEF;
                end
            end
            else if (has_n && !st_n)
            begin
                scan_assign = cnt_n == 2'd1;
                conflict    = cnt_n == 2'd0;
            end
        end
    end

    // trail pushes
    always_comb
    begin
        push_en  = 1'b0;
        push_lit = '0;
        if (scan_assign)
        begin
            push_en  = 1'b1;
            push_lit = acc_n;
        end
        else if (cmd.push_marker)
        begin
            push_en = 1'b1;
        end
        else if (cmd.push_dec)
        begin
            push_en  = 1'b1;
            push_lit = lit_t'(bidx_reg);
        end
        else if (cmd.bt_fin && (bt_lit_reg != '0))
        begin
            push_en  = 1'b1;
            push_lit = lit_t'(lit_t'(0) - bt_lit_reg);
        end
    end

    assign trail_we    = push_en && (tl_reg < TLW'(TDEPTH));
    assign trail_raddr = cmd.bt_rd ? TAW'(tl_reg - TLW'(1)) : TAW'(pp_reg);

    dss_ram #(.WIDTH(LIT_W), .DEPTH(MAX_LITS)) u_store (
        .clk   (clk),
        .we    (ld_store),
        .waddr (SAW'(lp_reg)),
        .wdata (literal),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    dss_ram #(.WIDTH(LIT_W), .DEPTH(TDEPTH)) u_trail (
        .clk   (clk),
        .we    (trail_we),
        .waddr (TAW'(tl_reg)),
        .wdata (push_lit),
        .raddr (trail_raddr),
        .rdata (trail_rdata)
    );

    dss_ram #(.WIDTH(AW), .DEPTH(MAX_VARS)) u_activity (
        .clk   (clk),
        .we    (act_we),
        .waddr (rd_addr_reg),
        .wdata (act_inc),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg      <= NV_W'(64);
            lp_reg      <= '0;
            open_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            asg_reg     <= '0;
            val_reg     <= '0;
            act_vld_reg <= '0;
            tl_reg      <= '0;
            pp_reg      <= '0;
            depth_reg   <= '0;
            cur_lit_reg <= '0;
            bt_lit_reg  <= '0;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            has_reg     <= 1'b0;
            st_reg      <= 1'b0;
            dcnt_reg    <= '0;
            best_reg    <= '0;
            bidx_reg    <= '0;
            ld_pend_reg <= 1'b0;
            rd_addr_reg <= '0;
            rd_vld_reg  <= 1'b0;
            wr_done_reg <= 1'b0;
            wr_addr_reg <= '0;
            wr_data_reg <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                nv_reg <= cfg_write_data;
            end
            if (cmd.clear)
            begin
                lp_reg      <= '0;
                open_reg    <= 1'b0;
                ovf_reg     <= 1'b0;
                asg_reg     <= '0;
                val_reg     <= '0;
                act_vld_reg <= '0;
                tl_reg      <= '0;
                pp_reg      <= '0;
                depth_reg   <= '0;
                ld_pend_reg <= 1'b0;
                wr_done_reg <= 1'b0;
            end
            else
            begin
                if (ld_store)
                begin
                    lp_reg   <= lp_reg + LPW'(1);
                    open_reg <= lit_nz;
                end
                if (ld_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
                ld_pend_reg <= ld_bump;
                rd_addr_reg <= act_raddr;
                rd_vld_reg  <= act_vld_reg[act_raddr];
                wr_done_reg <= act_we;
                wr_addr_reg <= rd_addr_reg;
                wr_data_reg <= act_inc;
                if (act_we)
                begin
                    act_vld_reg[rd_addr_reg] <= 1'b1;
                end

                if (cmd.scan_start)
                begin
                    pos_reg <= '0;
                    cnt_reg <= '0;
                    acc_reg <= '0;
                    has_reg <= 1'b0;
                    st_reg  <= 1'b0;
                end
                if (cmd.scan_step)
                begin
                    pos_reg <= pos_reg + SAW'(1);
                    if (close)
                    begin
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        has_reg <= 1'b0;
                        st_reg  <= 1'b0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_n;
                        acc_reg <= acc_n;
                        has_reg <= has_n;
                        st_reg  <= st_n;
                    end
                end

                if (cmd.set_lit)
                begin
                    cur_lit_reg <= trail_rdata;
                end
                if (cmd.pp_inc)
                begin
                    pp_reg <= pp_reg + TLW'(1);
                end
                if (cmd.push_marker)
                begin
                    pp_reg    <= pp_reg + TLW'(1);
                    depth_reg <= depth_reg + DW'(1);
                end

                if (cmd.bt_init)
                begin
                    bt_lit_reg <= '0;
                end
                if (cmd.bt_pop)
                begin
                    tl_reg <= tl_reg - TLW'(1);
                    if (trail_rdata != '0)
                    begin
                        asg_reg[vidx(trail_rdata)] <= 1'b0;
                        bt_lit_reg <= trail_rdata;
                    end
                end
                if (cmd.bt_fin)
                begin
                    if (depth_reg != '0)
                    begin
                        depth_reg <= depth_reg - DW'(1);
                    end
                    pp_reg <= tl_reg;
                end

                if (trail_we)
                begin
                    tl_reg <= tl_reg + TLW'(1);
                end
                if (push_en && (push_lit != '0))
                begin
                    asg_reg[vidx(push_lit)] <= 1'b1;
                    val_reg[vidx(push_lit)] <= !push_lit[LIT_W-1];
                end

                if (cmd.dec_start)
                begin
                    dcnt_reg <= '0;
                    best_reg <= '0;
                    bidx_reg <= '0;
                end
                if (cmd.dec_step)
                begin
                    dcnt_reg <= dcnt_reg + VIW'(1);
                    if (cand)
                    begin
                        best_reg <= actv;
                        bidx_reg <= NV_W'(dcnt_reg) + NV_W'(1);
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= RES_SAT;
            assign_reg    <= '0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
            status_reg    <= cmd.emit_code;
            assign_reg    <= (cmd.emit_code == RES_SAT) ? (asg_reg & val_reg & mask) : '0;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign assignment = assign_reg;

    assign sts.ovf            = ovf_reg;
    assign sts.lp_zero        = lp_reg == '0;
    assign sts.unsat          = unsat;
    assign sts.conflict       = conflict;
    assign sts.pp_lt_len      = pp_reg < tl_reg;
    assign sts.trail_lit_zero = trail_rdata == '0;
    assign sts.eff_zero       = eff == '0;
    assign sts.dec_last       = (NV_W'(dcnt_reg) + NV_W'(1)) == eff;
    assign sts.dec_found      = best_reg != '0;
    assign sts.depth_zero     = depth_reg == '0;
    assign sts.trail_empty    = tl_reg == '0;
    assign sts.out_free       = !out_valid_reg || !out_stall;

endmodule

@@ design/dpll_sat_solver.sv @@
// Top level of the DPLL SAT solver: sequencer, datapath and checks.
// Literals load at one per cycle while in_stall is low, DIMACS style, into a
// clause RAM of MAX_LITS entries while each occurrence bumps its variable's
// activity count. The item with last set holds in_stall high for the whole
// search: the unit scan, and one pass per propagated trail literal, read the
// clause RAM entry by entry; a conflict bumps an activity count, backtracking
// pops trail entries one at a time, and a decision scans the active variables.
// The clause RAM read port sets the search time, which depends on the formula.
// One result (status, assignment) follows each last item; it waits in an
// output register while loading of the next formula proceeds.
module dpll_sat_solver
    import dss_pkg::*;
#(
    parameter int MAX_VARS       = 64,
    parameter int MAX_LITS       = 1024,
    parameter int ACTIVITY_WIDTH = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [NV_W-1:0]     cfg_write_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [LIT_W-1:0]    literal,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [MAX_VARS-1:0] assignment
);

    cmd_t cmd;
    sts_t sts;

    dss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dss_datapath #(
        .MAX_VARS       (MAX_VARS),
        .MAX_LITS       (MAX_LITS),
        .ACTIVITY_WIDTH (ACTIVITY_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .literal        (literal),
        .cmd            (cmd),
        .sts            (sts),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .assignment     (assignment)
    );

`ifndef SYNTHESIS
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("input taken right after final transaction");

    a_zero_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != RES_SAT) |-> assignment == '0)
        else $error("assignment bits set on non-sat result");

    a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.scan_step, cmd.push_marker, cmd.push_dec, cmd.bt_fin}))
        else $error("trail push sources overlap");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("result transaction not presented");
`endif

endmodule

@@ bench/dpll_sat_solver_tb.sv @@
// Testbench for dpll_sat_solver: CNF formula streams checked against a built-in DPLL predictor.
`timescale 1ns / 100ps

module dpll_sat_solver_tb;
    import dss_pkg::*;

    localparam int NVARS     = 64;
    localparam int STORE_LEN = 1024;
    localparam int ACT_TOP   = (1 << 24) - 1;
    localparam int TRAIL_LEN = 2 * NVARS;
    localparam int WDOG_MAX  = 500000;
    localparam int HOLD_LEN  = 400;

    typedef struct packed {
        logic [LIT_W-1:0] lit;
        logic             lst;
    } lit_item_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write_en = 1'b0;
    logic [NV_W-1:0]     cfg_write_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [LIT_W-1:0]    literal = '0;
    logic                last = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          status;
    logic [NVARS-1:0]    assignment;

    lit_item_t        pending_lits[$];
    res_t             status_due[$];
    logic [NVARS-1:0] model_due[$];

    int  fails = 0;
    int  send_idle_pct = 27;
    int  recv_idle_pct = 77;
    bit  hold_start = 1'b0;
    int  hold_cnt = 0;
    int  quiet_cycles = 0;

    // solver state mirror
    int unsigned      nv_reg;
    logic [7:0]       clause_mem[STORE_LEN];
    lval_t            var_val[NVARS+1];
    int unsigned      act_cnt[NVARS+1];
    int               trail_q[TRAIL_LEN];
    int unsigned      trail_n, prop_ptr, dec_depth, load_ptr;
    bit               ovf_seen;

    dpll_sat_solver i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .literal        (literal),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .assignment     (assignment)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned active_vars();
        return nv_reg > NVARS ? NVARS : nv_reg;
    endfunction

    function automatic int unsigned magn(int l);
        return l < 0 ? -l : l;
    endfunction

    function automatic int as_int(logic [7:0] b);
        return int'($signed(b));
    endfunction

    function automatic void clear_formula();
        for (int i = 0; i <= NVARS; i++)
        begin
            var_val[i] = LV_UNDEF;
            act_cnt[i] = 0;
        end
        trail_n = 0;
        prop_ptr = 0;
        dec_depth = 0;
        load_ptr = 0;
        ovf_seen = 1'b0;
    endfunction

    function automatic void bump_act(int unsigned v);
        if (v <= NVARS && act_cnt[v] < ACT_TOP)
            act_cnt[v]++;
    endfunction

    function automatic lval_t lit_truth(int l);
        int unsigned v;
        v = magn(l);
        if (v > NVARS || var_val[v] == LV_UNDEF)
            return LV_UNDEF;
        if (l > 0)
            return var_val[v];
        return var_val[v] == LV_TRUE ? LV_FALSE : LV_TRUE;
    endfunction

    function automatic void set_lit(int l);
        int unsigned v;
        v = magn(l);
        if (trail_n < TRAIL_LEN)
        begin
            trail_q[trail_n] = l;
            trail_n++;
        end
        if (v >= 1 && v <= NVARS)
            var_val[v] = l > 0 ? LV_TRUE : LV_FALSE;
    endfunction

    function automatic bit prop_one(int l);
        int unsigned pos, start, stop, undefs;
        bit has, some_true;
        int last_undef, cl;
        lval_t tv;
        pos = 0;
        while (pos < load_ptr)
        begin
            start = pos;
            has = 1'b0;
            while (pos < load_ptr && clause_mem[pos] != 0)
            begin
                if (as_int(clause_mem[pos]) == -l)
                    has = 1'b1;
                pos++;
            end
            stop = pos;
            if (pos < load_ptr)
                pos++;
            if (has)
            begin
                some_true = 1'b0;
                undefs = 0;
                last_undef = 0;
                for (int unsigned j = start; j < stop && !some_true; j++)
                begin
                    cl = as_int(clause_mem[j]);
                    tv = lit_truth(cl);
                    if (tv == LV_TRUE)
                        some_true = 1'b1;
                    else if (tv == LV_UNDEF)
                    begin
                        undefs++;
                        last_undef = cl;
                    end
                end
                if (!some_true && undefs < 2)
                begin
                    if (undefs == 1)
                        set_lit(last_undef);
                    else
                    begin
                        bump_act(magn(l));
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic bit prop_all();
        while (prop_ptr < trail_n)
        begin
            if (trail_q[prop_ptr] != 0 && prop_one(trail_q[prop_ptr]))
                return 1'b1;
            prop_ptr++;
        end
        return 1'b0;
    endfunction

    function automatic void undo_level();
        int l;
        l = 0;
        while (trail_n > 0 && trail_q[trail_n-1] != 0)
        begin
            l = trail_q[trail_n-1];
            if (magn(l) <= NVARS)
                var_val[magn(l)] = LV_UNDEF;
            trail_n--;
        end
        if (trail_n > 0)
            trail_n--;
        if (dec_depth > 0)
            dec_depth--;
        prop_ptr = trail_n;
        if (l != 0)
            set_lit(-l);
    endfunction

    function automatic int pick_var();
        int unsigned best, idx;
        best = 0;
        idx = 0;
        for (int unsigned i = 1; i <= active_vars(); i++)
        begin
            if (var_val[i] == LV_UNDEF && act_cnt[i] >= best)
            begin
                best = act_cnt[i];
                idx = i;
            end
        end
        return best == 0 ? 0 : int'(idx);
    endfunction

    function automatic res_t run_search();
        int unsigned pos, start;
        int l, d;
        lval_t tv;
        if (ovf_seen)
            return RES_OVF;
        pos = 0;
        while (pos < load_ptr)
        begin
            start = pos;
            while (pos < load_ptr && clause_mem[pos] != 0)
                pos++;
            if (pos - start == 1)
            begin
                l = as_int(clause_mem[start]);
                tv = lit_truth(l);
                if (tv == LV_FALSE)
                    return RES_UNSAT;
                if (tv == LV_UNDEF)
                    set_lit(l);
            end
            if (pos < load_ptr)
                pos++;
        end
        forever
        begin
            while (prop_all())
            begin
                if (dec_depth == 0)
                    return RES_UNSAT;
                undo_level();
            end
            d = pick_var();
            if (d == 0)
                return RES_SAT;
            if (trail_n < TRAIL_LEN)
            begin
                trail_q[trail_n] = 0;
                trail_n++;
            end
            prop_ptr++;
            dec_depth++;
            set_lit(d);
        end
    endfunction

    function automatic void solver_step(logic [7:0] raw, logic lst);
        int l;
        res_t st;
        logic [NVARS-1:0] bits;
        l = as_int(raw);
        bits = '0;
        if (!ovf_seen)
        begin
            if (l != 0)
            begin
                if (magn(l) > active_vars() || load_ptr >= STORE_LEN)
                    ovf_seen = 1'b1;
                else
                begin
                    clause_mem[load_ptr] = raw;
                    load_ptr++;
                    bump_act(magn(l));
                end
            end
            else if (load_ptr > 0 && clause_mem[load_ptr-1] != 0)
            begin
                if (load_ptr >= STORE_LEN)
                    ovf_seen = 1'b1;
                else
                begin
                    clause_mem[load_ptr] = 8'd0;
                    load_ptr++;
                end
            end
        end
        if (!lst)
            return;
        st = run_search();
        if (st == RES_SAT)
            for (int unsigned i = 1; i <= active_vars(); i++)
                if (var_val[i] == LV_TRUE)
                    bits[i-1] = 1'b1;
        status_due = {status_due, st};
        model_due = {model_due, bits};
        clear_formula();
    endfunction

    // driver: one transaction per accepting edge, prediction on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                solver_step(literal, last);
            if (!in_valid || !in_stall)
            begin
                if (pending_lits.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    literal  <= pending_lits[0].lit;
                    last     <= pending_lits[0].lst;
                    void'(pending_lits.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor, receiver stall and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX)
            begin
                $display("tb: failure");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                if (status_due.size() == 0)
                begin
                    $display("%0t: unexpected transaction status=%0d assignment=%h",
                             $time, status, assignment);
                    fails++;
                end
                else
                begin
                    if (status !== status_due[0])
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, status_due[0], status);
                        fails++;
                    end
                    if (assignment !== model_due[0])
                    begin
                        $display("%0t: assignment expected %h actual %h",
                                 $time, model_due[0], assignment);
                        fails++;
                    end
                    void'(status_due.pop_front());
                    void'(model_due.pop_front());
                end
            end
            if (hold_start && hold_cnt < HOLD_LEN)
            begin
                hold_cnt <= hold_cnt + 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= $urandom_range(0, 99) < recv_idle_pct;
        end
    end

    task automatic push_lit(int l, bit lst = 1'b0);
        lit_item_t it;
        it.lit = l[7:0];
        it.lst = lst;
        pending_lits = {pending_lits, it};
    endtask

    task automatic wait_idle();
        while (pending_lits.size() > 0 || in_valid || status_due.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_num_vars(int unsigned v);
        wait_idle();
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v[NV_W-1:0];
        nv_reg = v & 32'h7f;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // small random formula; mostly well formed, sometimes noise or empty clauses
    task automatic push_formula(int unsigned maxv);
        int unsigned k, ncl, len;
        int l;
        k = $urandom_range(1, maxv < 8 ? (maxv == 0 ? 1 : maxv) : 8);
        ncl = $urandom_range(1, 5);
        for (int c = 0; c < ncl; c++)
        begin
            len = $urandom_range(1, 3);
            for (int j = 0; j < len; j++)
            begin
                l = $urandom_range(1, k);
                if ($urandom_range(0, 1))
                    l = -l;
                if ($urandom_range(0, 99) < 2)
                    l = as_int(8'($urandom));
                if (c == ncl - 1 && j == len - 1 && $urandom_range(0, 1))
                begin
                    push_lit(l, 1'b1);
                    return;
                end
                push_lit(l);
            end
            push_lit(0);
            if ($urandom_range(0, 99) < 5)
                push_lit(0);
        end
        push_lit(0, 1'b1);
    endtask

    initial
    begin
        nv_reg = NVARS;
        clear_formula();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        write_num_vars(64);

        // directed
        push_lit(0, 1'b1);                                   // empty formula
        push_lit(64); push_lit(-64); push_lit(0); push_lit(0);
        push_lit(1); push_lit(0, 1'b1);                      // empty clause ignored
        push_lit(5); push_lit(0); push_lit(-5, 1'b1);        // unsat at level zero
        push_lit(1); push_lit(2); push_lit(0); push_lit(-1); push_lit(2); push_lit(0);
        push_lit(1); push_lit(-2); push_lit(0); push_lit(-1); push_lit(-2); push_lit(0, 1'b1);
        push_lit(-128); push_lit(3); push_lit(0, 1'b1);      // out of range
        push_lit(127); push_lit(65, 1'b1);

        write_num_vars(1);
        push_lit(1); push_lit(0); push_lit(-1, 1'b1);
        push_lit(-1); push_lit(2); push_lit(0, 1'b1);

        write_num_vars(0);
        push_lit(1, 1'b1);
        push_lit(0, 1'b1);

        write_num_vars(127);
        push_lit(64); push_lit(-63); push_lit(0); push_lit(-64, 1'b1);

        // store full at a clause end
        write_num_vars(64);
        for (int i = 0; i < 511; i++)
        begin
            push_lit($urandom_range(1, 64));
            push_lit(0);
        end
        push_lit(9);
        push_lit(-9);
        push_lit(0, 1'b1);

        // random: sender 27%, receiver 77%
        write_num_vars($urandom_range(1, 64));
        for (int n = 0; n < 3; n++)
            push_formula(nv_reg);
        write_num_vars(1);
        for (int n = 0; n < 2; n++)
            push_formula(nv_reg);

        write_num_vars(127);
        send_idle_pct = 77;
        recv_idle_pct = 27;
        for (int n = 0; n < 2; n++)
            push_formula(8);
        write_num_vars($urandom_range(2, 63));
        for (int n = 0; n < 2; n++)
            push_formula(nv_reg);

        write_num_vars(64);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_start = 1'b1;
        for (int n = 0; n < 3; n++)
            push_formula(nv_reg);

        wait_idle();
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
